// ===== hw/rtl/h3d_pkg.sv =====
package h3d_pkg;

    // Field widths of the external ports
    localparam int IDX_W   = 30;
    localparam int COORD_W = 10;
    localparam int RANK_W  = 30;
    localparam int LEVEL_W = 4;

    typedef logic [IDX_W-1:0]   t_index;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [LEVEL_W-1:0] t_level_cfg;

    // curve_level after reset
    localparam t_level_cfg LEVEL_RESET = 4'd10;

endpackage

// ===== hw/rtl/hilbert3d_index_to_coords_core.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-------------------------------------
// index    | in        | i_valid / o_stall      | i_hilbert_index
// coords   | out       | o_valid / i_stall      | o_coord_x, o_coord_y, o_coord_z,
//          |           |                        | o_raster_rank
// config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_curve_level
//
// Throughput: one index per cycle while the output side does not stall. The pipeline is the
// chain of untangle stages (one stage per curve level above the first), with
// the decode stage in front and the output register behind.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the curve
// level to 10. The config port is always ready.
// A stall from the output side only holds stages that carry an item; empty
// stages keep filling, so the input keeps taking transfers until the pipe is full.
module hilbert3d_index_to_coords_core #(
    parameter int MAX_LEVEL = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // index channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  h3d_pkg::t_index        i_hilbert_index,
    // coordinate channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output h3d_pkg::t_coord        o_coord_x,
    output h3d_pkg::t_coord        o_coord_y,
    output h3d_pkg::t_coord        o_coord_z,
    output h3d_pkg::t_rank         o_raster_rank,
    // config channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  h3d_pkg::t_level_cfg    i_cfg_curve_level
);
    import h3d_pkg::*;

    // Word width per axis, level width, and number of data stages
    localparam int W    = MAX_LEVEL;
    localparam int LW   = $clog2(MAX_LEVEL + 1);
    localparam int ST   = MAX_LEVEL;
    localparam int CMPW = (LW > LEVEL_W) ? LW : LEVEL_W;
    localparam int XW   = IDX_W + 3 * W;
    localparam int CXW  = W + COORD_W;
    localparam int RXW  = W + RANK_W;

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    t_level_cfg r_curve_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_level <= LEVEL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_curve_level <= i_cfg_curve_level;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when the next one does
    // ------------------------------------------------------------------
    logic [ST:0] r_vld;
    logic [ST:0] n_vld;
    logic [ST:0] adv;

    always_comb begin
        adv[ST] = !r_vld[ST] || !i_stall;
        for (int s = ST - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign n_vld   = {r_vld[ST-1:0], i_valid};
    assign o_stall = !adv[0];
    assign o_valid = r_vld[ST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (adv & n_vld) | (~adv & r_vld);
        end
    end

    // Stage data: three transposed words and the level of the item
    logic [W-1:0]  r_w0  [ST];
    logic [W-1:0]  r_w1  [ST];
    logic [W-1:0]  r_w2  [ST];
    logic [LW-1:0] r_lev [ST];

    // ------------------------------------------------------------------
    // Stage 0: level clamp, de-interleave, Gray decode
    // ------------------------------------------------------------------
    logic [CMPW-1:0] cfg_ext;
    logic [LW-1:0]   eff_lev;
    logic [XW-1:0]   idx_ext;
    logic [W-1:0]    dw0, dw1, dw2;
    logic [W-1:0]    n_w0_s0, n_w1_s0, n_w2_s0;

    always_comb begin
        cfg_ext = CMPW'(r_curve_level);
        if (cfg_ext == '0) begin
            eff_lev = LW'(1);
        end else if (cfg_ext > CMPW'(MAX_LEVEL)) begin
            eff_lev = LW'(MAX_LEVEL);
        end else begin
            eff_lev = LW'(cfg_ext);
        end
    end

    always_comb begin
        idx_ext = XW'(i_hilbert_index);
        dw0 = '0;
        dw1 = '0;
        dw2 = '0;
        // bit b of word i is index bit 3b + (2 - i), only below the level
        for (int b = 0; b < W; b++) begin
            if (b < int'(eff_lev)) begin
                dw0[b] = idx_ext[3*b+2];
                dw1[b] = idx_ext[3*b+1];
                dw2[b] = idx_ext[3*b];
            end
        end
        n_w2_s0 = dw2 ^ dw1;
        n_w1_s0 = dw1 ^ dw0;
        n_w0_s0 = dw0 ^ (dw2 >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_w0[0]  <= n_w0_s0;
            r_w1[0]  <= n_w1_s0;
            r_w2[0]  <= n_w2_s0;
            r_lev[0] <= eff_lev;
        end
    end

    // ------------------------------------------------------------------
    // Untangle stages: stage k handles bit k (exchange or invert below it)
    // ------------------------------------------------------------------
    for (genvar k = 1; k < MAX_LEVEL; k++) begin : g_untangle
        localparam logic [W-1:0] P = W'((64'd1 << k) - 64'd1);

        logic [W-1:0] n_w0, n_w1, n_w2;
        logic [W-1:0] t2, t1;

        always_comb begin
            n_w0 = r_w0[k-1];
            n_w1 = r_w1[k-1];
            n_w2 = r_w2[k-1];
            t2   = '0;
            t1   = '0;
            if (int'(r_lev[k-1]) > k) begin
                if (n_w2[k]) begin
                    n_w0 = n_w0 ^ P;
                end else begin
                    t2   = (n_w0 ^ n_w2) & P;
                    n_w0 = n_w0 ^ t2;
                    n_w2 = n_w2 ^ t2;
                end
                if (n_w1[k]) begin
                    n_w0 = n_w0 ^ P;
                end else begin
                    t1   = (n_w0 ^ n_w1) & P;
                    n_w0 = n_w0 ^ t1;
                    n_w1 = n_w1 ^ t1;
                end
                if (n_w0[k]) begin
                    n_w0 = n_w0 ^ P;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_w0[k]  <= n_w0;
                r_w1[k]  <= n_w1;
                r_w2[k]  <= n_w2;
                r_lev[k] <= r_lev[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: coordinates and raster rank z*N*N + y*N + x
    // ------------------------------------------------------------------
    logic [CXW-1:0]  cx_ext, cy_ext, cz_ext;
    logic [RXW-1:0]  rx_ext, ry_ext, rz_ext;
    t_rank           n_rank;
    t_coord          r_coord_x, r_coord_y, r_coord_z;
    t_rank           r_raster_rank;

    always_comb begin
        cx_ext = CXW'(r_w0[ST-1]);
        cy_ext = CXW'(r_w1[ST-1]);
        cz_ext = CXW'(r_w2[ST-1]);
        rx_ext = RXW'(r_w0[ST-1]);
        ry_ext = RXW'(r_w1[ST-1]);
        rz_ext = RXW'(r_w2[ST-1]);
        n_rank = (rz_ext[RANK_W-1:0] << {r_lev[ST-1], 1'b0})
               | (ry_ext[RANK_W-1:0] << r_lev[ST-1])
               | rx_ext[RANK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST]) begin
            r_coord_x     <= cx_ext[COORD_W-1:0];
            r_coord_y     <= cy_ext[COORD_W-1:0];
            r_coord_z     <= cz_ext[COORD_W-1:0];
            r_raster_rank <= n_rank;
        end
    end

    assign o_coord_x     = r_coord_x;
    assign o_coord_y     = r_coord_y;
    assign o_coord_z     = r_coord_z;
    assign o_raster_rank = r_raster_rank;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is free");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[ST-1]))
        else $error("result appeared without an item in the last stage");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_lev[0] != '0) && (int'(r_lev[0]) <= MAX_LEVEL))
        else $error("stage level out of range");

    a_words_below_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ((r_w0[0] >> r_lev[0]) == '0) && ((r_w1[0] >> r_lev[0]) == '0)
                     && ((r_w2[0] >> r_lev[0]) == '0))
        else $error("decoded word has bits above the level");

endmodule
